// File: hw/rtl/bms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

    // Action codes carried on the input channel.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_PLAY = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam int unsigned MELODY_COUNT        = 5;
    localparam int unsigned TIMER_CLOCK_HZ_DFLT = 1000000;

    // Tone codes stored in the melody ROM. The timer values of each tone
    // are worked out from the timer clock when the design is elaborated.
    typedef enum logic [2:0] {
        TONE_REST = 3'd0,
        TONE_1K   = 3'd1,
        TONE_2K   = 3'd2,
        TONE_3K   = 3'd3,
        TONE_3K5  = 3'd4,
        TONE_4K   = 3'd5,
        TONE_5K   = 3'd6
    } t_tone;

    typedef struct packed {
        t_tone      tone;
        logic [8:0] dur;
    } t_rom_entry;

    // Decoded note as seen by the sequencer.
    typedef struct packed {
        logic       last;
        logic       rest;
        logic [9:0] reload;
        logic [8:0] compare;
        logic [8:0] dur;
    } t_note;

    // Melody ROM. A rest with zero duration ends a melody; every slot past
    // the stored entries, and every invalid melody, reads as that terminator.
    function automatic t_rom_entry melody_entry(input logic [2:0] melody,
                                                input logic [2:0] index);
        t_rom_entry e;
        e = '{tone: TONE_REST, dur: 9'd0};
        unique case ({melody, index})
            {3'd0, 3'd0}: e = '{tone: TONE_3K,  dur: 9'd200};
            {3'd0, 3'd1}: e = '{tone: TONE_3K5, dur: 9'd200};
            {3'd0, 3'd2}: e = '{tone: TONE_4K,  dur: 9'd400};
            {3'd1, 3'd0}: e = '{tone: TONE_4K,  dur: 9'd100};
            {3'd1, 3'd1}: e = '{tone: TONE_REST, dur: 9'd50};
            {3'd2, 3'd0}: e = '{tone: TONE_2K,  dur: 9'd300};
            {3'd2, 3'd1}: e = '{tone: TONE_REST, dur: 9'd100};
            {3'd2, 3'd2}: e = '{tone: TONE_4K,  dur: 9'd200};
            {3'd2, 3'd3}: e = '{tone: TONE_REST, dur: 9'd100};
            {3'd2, 3'd4}: e = '{tone: TONE_4K,  dur: 9'd400};
            {3'd3, 3'd0}: e = '{tone: TONE_4K,  dur: 9'd100};
            {3'd3, 3'd1}: e = '{tone: TONE_3K,  dur: 9'd100};
            {3'd3, 3'd2}: e = '{tone: TONE_2K,  dur: 9'd100};
            {3'd3, 3'd3}: e = '{tone: TONE_1K,  dur: 9'd200};
            {3'd4, 3'd0}: e = '{tone: TONE_4K,  dur: 9'd100};
            {3'd4, 3'd1}: e = '{tone: TONE_REST, dur: 9'd50};
            {3'd4, 3'd2}: e = '{tone: TONE_4K,  dur: 9'd100};
            {3'd4, 3'd3}: e = '{tone: TONE_5K,  dur: 9'd150};
            {3'd4, 3'd4}: e = '{tone: TONE_4K,  dur: 9'd200};
            default:      e = '{tone: TONE_REST, dur: 9'd0};
        endcase
        return e;
    endfunction

    // Reload is the period minus one, saturated to ten bits.
    function automatic logic [9:0] sat_reload(input int unsigned q);
        logic [9:0] r;
        if (q == 0) begin
            r = 10'd0;
        end else if (q - 1 > 1023) begin
            r = 10'd1023;
        end else begin
            r = 10'(q - 1);
        end
        return r;
    endfunction

    // Compare is half the period, saturated to nine bits.
    function automatic logic [8:0] sat_compare(input int unsigned q);
        logic [8:0] c;
        if ((q >> 1) > 511) begin
            c = 9'd511;
        end else begin
            c = 9'(q >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bms_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] melody_select;

    modport source (output valid, output action, output melody_select, input ready);
    modport sink   (input valid, input action, input melody_select, output ready);
endinterface

interface bms_out_if;
    logic       valid;
    logic       ready;
    logic       tone_on;
    logic [9:0] reload_value;
    logic [8:0] compare_value;
    logic       timer_load;
    logic       playing;

    modport source (output valid, output tone_on, output reload_value,
                    output compare_value, output timer_load, output playing,
                    input ready);
    modport sink   (input valid, input tone_on, input reload_value,
                    input compare_value, input timer_load, input playing,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bms_note_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_note_rom
    import bms_pkg::*;
#(
    parameter int unsigned TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DFLT
) (
    input  wire logic [2:0] i_melody,
    input  wire logic [2:0] i_index,
    output t_note           o_note
);

    // Timer quotients per tone, fixed at elaboration.
    localparam int unsigned Q_1K  = TIMER_CLOCK_HZ / 1000;
    localparam int unsigned Q_2K  = TIMER_CLOCK_HZ / 2000;
    localparam int unsigned Q_3K  = TIMER_CLOCK_HZ / 3000;
    localparam int unsigned Q_3K5 = TIMER_CLOCK_HZ / 3500;
    localparam int unsigned Q_4K  = TIMER_CLOCK_HZ / 4000;
    localparam int unsigned Q_5K  = TIMER_CLOCK_HZ / 5000;

    t_rom_entry w_entry;

    always_comb begin
        w_entry        = melody_entry(i_melody, i_index);
        o_note.dur     = w_entry.dur;
        o_note.rest    = (w_entry.tone == TONE_REST);
        o_note.last    = (w_entry.tone == TONE_REST) && (w_entry.dur == 9'd0);
        unique case (w_entry.tone)
            TONE_1K: begin
                o_note.reload  = sat_reload(Q_1K);
                o_note.compare = sat_compare(Q_1K);
            end
            TONE_2K: begin
                o_note.reload  = sat_reload(Q_2K);
                o_note.compare = sat_compare(Q_2K);
            end
            TONE_3K: begin
                o_note.reload  = sat_reload(Q_3K);
                o_note.compare = sat_compare(Q_3K);
            end
            TONE_3K5: begin
                o_note.reload  = sat_reload(Q_3K5);
                o_note.compare = sat_compare(Q_3K5);
            end
            TONE_4K: begin
                o_note.reload  = sat_reload(Q_4K);
                o_note.compare = sat_compare(Q_4K);
            end
            TONE_5K: begin
                o_note.reload  = sat_reload(Q_5K);
                o_note.compare = sat_compare(Q_5K);
            end
            default: begin
                o_note.reload  = 10'd0;
                o_note.compare = 9'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/buzzer_melody_sequencer_core.sv
// A beat accepted at the input passes the input register, then the state
// update and the result register. Throughput: one beat per cycle while the
// sink takes results; the only path is the note ROM lookup and a 9-bit counter
// add and compare between the input and result registers.
// Reset (i_rst_n, synchronous, active low) clears the sequencer state, the
// timer values and both valid flags; the block takes beats right after it.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_melody_sequencer_core
    import bms_pkg::*;
#(
    parameter int unsigned TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DFLT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bms_in_if.sink    i_in,
    bms_out_if.source o_out
);

    // Input register stage.
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic [2:0] r_in_sel;

    // Sequencer state.
    logic [2:0] r_melody, n_melody;
    logic [2:0] r_index,  n_index;
    logic [8:0] r_count,  n_count;
    logic       r_playing, n_playing;
    logic       r_tone,   n_tone;
    logic [9:0] r_period, n_period;
    logic [8:0] r_compare, n_compare;
    logic       n_load;

    // Result register stage.
    logic       r_out_valid;
    logic       r_out_tone;
    logic [9:0] r_out_reload;
    logic [8:0] r_out_compare;
    logic       r_out_load;
    logic       r_out_playing;

    logic       w_out_free;
    logic       w_adv;
    logic [8:0] w_count_inc;
    t_note      w_note;

    // The result register can take a new beat when it is empty or being
    // drained this cycle; the input register advances whenever it can.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_sel    <= i_in.melody_select;
        end
    end

    // The current note of the current melody, with its timer values.
    bms_note_rom #(
        .TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)
    ) u_note_rom (
        .i_melody(r_melody),
        .i_index (r_index),
        .o_note  (w_note)
    );

    assign w_count_inc = r_count + 9'd1;

    // One beat of sequencer work. A play beat first stops what is running,
    // which switches the tone off only if a melody was in progress. A tick
    // steps the note counter; the first tick of a note programs the timer
    // or, for a rest, silences it. An invalid melody only drops the playing
    // flag and leaves the tone as it was.
    always_comb begin
        n_melody  = r_melody;
        n_index   = r_index;
        n_count   = r_count;
        n_playing = r_playing;
        n_tone    = r_tone;
        n_period  = r_period;
        n_compare = r_compare;
        n_load    = 1'b0;
        unique case (r_in_action)
            ACT_PLAY: begin
                if (r_playing) begin
                    n_tone = 1'b0;
                end
                n_melody  = r_in_sel;
                n_index   = 3'd0;
                n_count   = 9'd0;
                n_playing = 1'b1;
            end
            ACT_STOP: begin
                n_tone    = 1'b0;
                n_playing = 1'b0;
                n_index   = 3'd0;
                n_count   = 9'd0;
            end
            ACT_TICK: begin
                if (r_playing) begin
                    if (r_melody >= 3'(MELODY_COUNT)) begin
                        n_playing = 1'b0;
                    end else if (w_note.last) begin
                        n_tone    = 1'b0;
                        n_playing = 1'b0;
                        n_index   = 3'd0;
                        n_count   = 9'd0;
                    end else begin
                        n_count = w_count_inc;
                        if (w_count_inc == 9'd1) begin
                            if (w_note.rest) begin
                                n_tone = 1'b0;
                            end else begin
                                n_period  = w_note.reload;
                                n_compare = w_note.compare;
                                n_tone    = 1'b1;
                                n_load    = 1'b1;
                            end
                        end
                        if (w_count_inc >= w_note.dur) begin
                            n_index = r_index + 3'd1;
                            n_count = 9'd0;
                        end
                    end
                end
            end
            default: begin
                // Unused action code: the state holds.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_melody  <= 3'd0;
            r_index   <= 3'd0;
            r_count   <= 9'd0;
            r_playing <= 1'b0;
            r_tone    <= 1'b0;
            r_period  <= 10'd0;
            r_compare <= 9'd0;
        end else if (w_adv) begin
            r_melody  <= n_melody;
            r_index   <= n_index;
            r_count   <= n_count;
            r_playing <= n_playing;
            r_tone    <= n_tone;
            r_period  <= n_period;
            r_compare <= n_compare;
        end
    end

    // Result register: holds a finished beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_tone    <= n_tone;
            r_out_reload  <= n_period;
            r_out_compare <= n_compare;
            r_out_load    <= n_load;
            r_out_playing <= n_playing;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tone_on       = r_out_tone;
    assign o_out.reload_value  = r_out_reload;
    assign o_out.compare_value = r_out_compare;
    assign o_out.timer_load    = r_out_load;
    assign o_out.playing       = r_out_playing;

    // A beat that reprogrammed the timer always leaves the tone running.
    a_load_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.timer_load) |-> o_out.tone_on)
        else $error("timer load reported with the tone off");

    // A stop beat leaves the sequencer silent and idle.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_action == ACT_STOP) |=> (!r_playing && !r_tone))
        else $error("stop did not silence the sequencer");

    // The note counter only runs while a melody is in progress.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_playing |-> (r_count == 9'd0))
        else $error("note counter nonzero while idle");

endmodule

`default_nettype wire

// File: test/buzzer_melody_sequencer_core_tb.sv
`timescale 1ns / 1ps

module buzzer_melody_sequencer_core_tb;
    import bms_pkg::*;

    // The block has no code for action 3; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned TUNE_SLOTS  = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BEAT_TARGET = 1950;
    localparam int unsigned PHASE_BEATS = BEAT_TARGET / 3;

    // Tone table of every melody: frequency in Hz (0 is a rest) and the note
    // length in 1 ms ticks. A slot with zero frequency and zero length ends
    // the melody, and so does every slot past the stored notes.
    localparam int unsigned NOTE_HZ [MELODY_COUNT][TUNE_SLOTS] = '{
        '{3000, 3500, 4000, 0, 0, 0, 0, 0},
        '{4000, 0, 0, 0, 0, 0, 0, 0},
        '{2000, 0, 4000, 0, 4000, 0, 0, 0},
        '{4000, 3000, 2000, 1000, 0, 0, 0, 0},
        '{4000, 0, 4000, 5000, 4000, 0, 0, 0}
    };
    localparam int unsigned NOTE_MS [MELODY_COUNT][TUNE_SLOTS] = '{
        '{200, 200, 400, 0, 0, 0, 0, 0},
        '{100, 50, 0, 0, 0, 0, 0, 0},
        '{300, 100, 200, 100, 400, 0, 0, 0},
        '{100, 100, 100, 200, 0, 0, 0, 0},
        '{100, 50, 100, 150, 200, 0, 0, 0}
    };

    // One result beat, field by field.
    typedef struct packed {
        logic       tone_on;
        logic [9:0] reload_value;
        logic [8:0] compare_value;
        logic       timer_load;
        logic       playing;
    } t_tone_result;

    // Tracks the sequencer state on its own and keeps the queue of result
    // beats still owed by the block.
    class tone_scoreboard;
        logic [2:0]   tune_sel;
        logic [2:0]   note_pos;
        logic [8:0]   note_ticks;
        logic         busy;
        logic         sounding;
        logic [9:0]   reload_q;
        logic [8:0]   compare_q;
        t_tone_result pending_tones[$];
        int unsigned  mismatch_count;

        function new();
            tune_sel       = '0;
            note_pos       = '0;
            note_ticks     = '0;
            busy           = 1'b0;
            sounding       = 1'b0;
            reload_q       = '0;
            compare_q      = '0;
            mismatch_count = 0;
        endfunction

        function void silence();
            sounding   = 1'b0;
            busy       = 1'b0;
            note_pos   = '0;
            note_ticks = '0;
        endfunction

        // Advances the sequencer by one accepted command and queues the beat
        // that the block must answer with.
        function void log_command(input logic [1:0] act, input logic [2:0] sel);
            int unsigned  hz;
            int unsigned  ms;
            int unsigned  q;
            logic         loaded;
            t_tone_result exp_beat;
            loaded = 1'b0;
            case (act)
                ACT_PLAY: begin
                    // A new play always starts over; a running tune is stopped first.
                    if (busy) begin
                        silence();
                    end
                    tune_sel   = sel;
                    note_pos   = '0;
                    note_ticks = '0;
                    busy       = 1'b1;
                end
                ACT_STOP: begin
                    silence();
                end
                ACT_TICK: begin
                    if (busy && tune_sel >= MELODY_COUNT) begin
                        // Invalid melody: only the playing flag drops.
                        busy = 1'b0;
                    end else if (busy) begin
                        hz = NOTE_HZ[tune_sel][note_pos];
                        ms = NOTE_MS[tune_sel][note_pos];
                        if (hz == 0 && ms == 0) begin
                            silence();
                        end else begin
                            note_ticks = note_ticks + 9'd1;
                            if (note_ticks == 9'd1) begin
                                if (hz == 0) begin
                                    // A rest keeps the last timer values.
                                    sounding = 1'b0;
                                end else begin
                                    q = TIMER_CLOCK_HZ_DFLT / hz;
                                    if (q == 0) begin
                                        reload_q = '0;
                                    end else if (q - 1 > 1023) begin
                                        reload_q = 10'd1023;
                                    end else begin
                                        reload_q = 10'(q - 1);
                                    end
                                    compare_q = (q / 2 > 511) ? 9'd511 : 9'(q / 2);
                                    sounding  = 1'b1;
                                    loaded    = 1'b1;
                                end
                            end
                            if (note_ticks >= ms) begin
                                note_pos   = note_pos + 3'd1;
                                note_ticks = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            exp_beat.tone_on       = sounding;
            exp_beat.reload_value  = reload_q;
            exp_beat.compare_value = compare_q;
            exp_beat.timer_load    = loaded;
            exp_beat.playing       = busy;
            pending_tones.push_back(exp_beat);
        endfunction

        function void check_output(input t_tone_result got);
            t_tone_result exp_beat;
            if (pending_tones.size() == 0) begin
                $error("result beat with no command waiting for it");
                mismatch_count++;
                return;
            end
            exp_beat = pending_tones.pop_front();
            if (got.tone_on !== exp_beat.tone_on) begin
                $error("tone_on: expected %0d, got %0d", exp_beat.tone_on, got.tone_on);
                mismatch_count++;
            end
            if (got.reload_value !== exp_beat.reload_value) begin
                $error("reload_value: expected %0d, got %0d",
                       exp_beat.reload_value, got.reload_value);
                mismatch_count++;
            end
            if (got.compare_value !== exp_beat.compare_value) begin
                $error("compare_value: expected %0d, got %0d",
                       exp_beat.compare_value, got.compare_value);
                mismatch_count++;
            end
            if (got.timer_load !== exp_beat.timer_load) begin
                $error("timer_load: expected %0d, got %0d",
                       exp_beat.timer_load, got.timer_load);
                mismatch_count++;
            end
            if (got.playing !== exp_beat.playing) begin
                $error("playing: expected %0d, got %0d", exp_beat.playing, got.playing);
                mismatch_count++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bms_in_if  tone_in ();
    bms_out_if tone_out ();

    buzzer_melody_sequencer_core #(
        .TIMER_CLOCK_HZ(TIMER_CLOCK_HZ_DFLT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (tone_in),
        .o_out  (tone_out)
    );

    tone_scoreboard sb = new();

    // Idle rates in percent for the command side and the result side. The
    // stimulus switches them per phase.
    int unsigned src_gap_pct   = 38;
    int unsigned snk_stall_pct = 60;
    int unsigned sent_beats    = 0;
    int unsigned beat_goal     = 0;
    int unsigned cycle_count   = 0;

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Inputs of the block only move on the falling edge, so every rising edge
    // sees settled values on both sides.
    initial begin
        i_rst_n                = 1'b0;
        tone_in.valid          = 1'b0;
        tone_in.action         = ACT_TICK;
        tone_in.melody_select  = '0;
        tone_out.ready         = 1'b0;
    end

    // Result side back pressure.
    always @(negedge i_clk) begin
        tone_out.ready = ($urandom_range(99) >= snk_stall_pct);
    end

    // Every result beat is checked at the rising edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && tone_out.valid && tone_out.ready) begin
            sb.check_output('{tone_on:       tone_out.tone_on,
                              reload_value:  tone_out.reload_value,
                              compare_value: tone_out.compare_value,
                              timer_load:    tone_out.timer_load,
                              playing:       tone_out.playing});
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sends one command beat. Entered and left on a falling edge. A random
    // number of idle cycles comes first; valid then stays up until the beat
    // is taken, and it is not dropped between back to back beats.
    task automatic send_cmd(input logic [1:0] act, input logic [2:0] sel);
        logic accepted;
        accepted = 1'b0;
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            tone_in.valid = 1'b0;
            @(negedge i_clk);
        end
        // Every beat sent counts toward the target.
        sent_beats++;
        tone_in.valid         = 1'b1;
        tone_in.action        = act;
        tone_in.melody_select = sel;
        while (!accepted) begin
            @(posedge i_clk);
            if (tone_in.ready) begin
                sb.log_command(act, sel);
                accepted = 1'b1;
            end
        end
        @(negedge i_clk);
    endtask

    // Holds the command side off until the block has answered every beat.
    task automatic drain_results();
        tone_in.valid = 1'b0;
        while (sb.pending_tones.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Starts a melody and feeds it ticks. Now and then a tick is replaced by
    // noise: the unused code, a stop, or a restart with a random melody.
    task automatic play_tune(input logic [2:0] sel, input int unsigned n_ticks);
        int unsigned r;
        send_cmd(ACT_PLAY, sel);
        for (int unsigned k = 0; k < n_ticks; k++) begin
            r = $urandom_range(999);
            if (r < 10) begin
                send_cmd(ACT_UNUSED, 3'($urandom_range(7)));
            end else if (r < 15) begin
                send_cmd(ACT_STOP, 3'($urandom_range(7)));
            end else if (r < 20) begin
                send_cmd(ACT_PLAY, 3'($urandom_range(7)));
            end else begin
                send_cmd(ACT_TICK, 3'($urandom_range(7)));
            end
        end
    endtask

    // Ticks that carry a melody through its last note and onto the end mark.
    function automatic int unsigned tune_length(input logic [2:0] sel);
        int unsigned total;
        total = 1;
        for (int unsigned k = 0; k < TUNE_SLOTS; k++) begin
            total += NOTE_MS[sel][k];
        end
        return total;
    endfunction

    // One random melody session. Most sessions use a valid melody; a good
    // share run all the way to the end mark so that rests and the end of
    // playback are reached often, the rest break off part way. A session
    // never runs far past the beat goal of its phase.
    task automatic random_session();
        logic [2:0]  sel;
        int unsigned n_ticks;
        int unsigned room;
        if ($urandom_range(99) < 12) begin
            sel     = 3'($urandom_range(7, MELODY_COUNT));
            n_ticks = $urandom_range(1, 4);
        end else begin
            sel = 3'($urandom_range(MELODY_COUNT - 1));
            if ($urandom_range(99) < 35) begin
                n_ticks = tune_length(sel) + $urandom_range(0, 3);
            end else begin
                n_ticks = $urandom_range(1, 250);
            end
        end
        room = (beat_goal > sent_beats) ? beat_goal - sent_beats : 1;
        if (n_ticks > room) begin
            n_ticks = room;
        end
        play_tune(sel, n_ticks);
        if ($urandom_range(99) < 30) begin
            send_cmd(ACT_STOP, 3'($urandom_range(7)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Commands on an idle sequencer and the unused code first.
        send_cmd(ACT_TICK, 3'd0);
        send_cmd(ACT_UNUSED, 3'd7);
        send_cmd(ACT_STOP, 3'd5);
        // An invalid melody drops the playing flag on its first tick.
        send_cmd(ACT_PLAY, 3'd5);
        send_cmd(ACT_TICK, 3'd0);
        // Play from idle, then the first note programs the timer.
        send_cmd(ACT_PLAY, 3'd1);
        send_cmd(ACT_TICK, 3'd2);
        send_cmd(ACT_TICK, 3'd3);
        // Invalid melody while a tone sounds: the restart silences it first.
        send_cmd(ACT_PLAY, 3'd6);
        send_cmd(ACT_TICK, 3'd1);
        // Restart of a running melody.
        send_cmd(ACT_PLAY, 3'd3);
        send_cmd(ACT_TICK, 3'd4);
        send_cmd(ACT_PLAY, 3'd3);
        send_cmd(ACT_TICK, 3'd6);
        // Stop in the middle of a note, then a tick on the idle block.
        send_cmd(ACT_STOP, 3'd7);
        send_cmd(ACT_TICK, 3'd5);
        // First note of each of the remaining melodies and the last invalid one.
        send_cmd(ACT_PLAY, 3'd0);
        send_cmd(ACT_TICK, 3'd0);
        send_cmd(ACT_PLAY, 3'd2);
        send_cmd(ACT_TICK, 3'd0);
        send_cmd(ACT_PLAY, 3'd4);
        send_cmd(ACT_TICK, 3'd0);
        send_cmd(ACT_PLAY, 3'd7);
        send_cmd(ACT_TICK, 3'd0);
        drain_results();

        // The short melody holds a rest and reaches its end mark quickly.
        play_tune(3'd1, tune_length(3'd1) + 2);

        // Random part in three phases of idling, with a full drain between them.
        for (int unsigned phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_gap_pct   = 38;
                    snk_stall_pct = 60;
                end
                1: begin
                    src_gap_pct   = 60;
                    snk_stall_pct = 38;
                end
                default: begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 0;
                end
            endcase
            beat_goal = (phase + 1) * PHASE_BEATS;
            while (sent_beats < beat_goal) begin
                random_session();
            end
            drain_results();
        end

        // Leave room for any stray beat to show up.
        repeat (8) @(negedge i_clk);
        if (sb.pending_tones.size() != 0) begin
            $error("%0d result beats never arrived", sb.pending_tones.size());
        end
        if (sb.mismatch_count == 0 && sb.pending_tones.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: buzzer_melody_sequencer_core.f
hw/rtl/bms_pkg.sv
hw/rtl/bms_if.sv
hw/rtl/bms_note_rom.sv
hw/rtl/buzzer_melody_sequencer_core.sv
test/buzzer_melody_sequencer_core_tb.sv
